FILE: design/tftg_pkg.sv
package tftg_pkg;

    localparam int TIME_W      = 32;
    localparam int SINE_DEPTH  = 256;
    localparam int SINE_LOG2   = 8;
    localparam int PERIOD_W    = 24;
    localparam int LEN_W       = 16;
    localparam int GROUND_W    = 17;
    localparam int PHASE_W     = 16;
    localparam int X_W         = 17;
    localparam int Z_W         = 18;
    localparam int SINE_W      = 17;
    // time bits, then one bit for the half-cycle index, then the phase bits
    localparam int DIV_STEPS   = TIME_W + 1 + PHASE_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int IDX_W       = SINE_LOG2 + 1;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(2000000);
    localparam logic [LEN_W-1:0]    STEP_RST   = LEN_W'(6554);
    localparam logic [LEN_W-1:0]    LIFT_RST   = LEN_W'(4588);
    localparam logic [GROUND_W-1:0] GROUND_RST = GROUND_W'(-18350);

    typedef logic [SINE_DEPTH:0][SINE_W-1:0] t_sine_tab;

    // quarter-wave sine, 65536 * sin(pi*k/(2*depth)), series in q30
    function automatic t_sine_tab build_sine();
        t_sine_tab          tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] s;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x    = (PI_HALF_Q30 * 64'(k) + 64'(SINE_DEPTH / 2)) / 64'(SINE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            s    = $signed(x);
            term = ((term * x2) >> 30) / 64'd6;
            s    = s - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            s    = s + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            s    = s - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            s    = s + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            s    = s - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            s    = s + $signed(term);
            if (s < 0) begin
                s = 0;
            end
            s = (s + 64'sd8192) >>> 14;
            if (s > 64'sd65536) begin
                s = 64'sd65536;
            end
            tab[k] = s[SINE_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

endpackage

FILE: design/trot_foot_trajectory_generator.sv
// Trot gait foot trajectory generator. Each s_axis transfer carries a timestamp; the first
// one after reset latches the start time. Elapsed time modulo gait_period picks the half
// cycle and the Q0.16 phase within it, and the diagonal stance pair (FL+HR or FR+HL) swaps
// whenever the half-cycle index changes. One m_axis transfer with the x and z targets of all
// four feet, the stance mask and the phase follows every input. Each item runs through 49
// steps of the shared restoring divider (32 for the modulo, one for the half index, 16 for
// the phase), three passes through one shared 17x18 multiplier and a final rounding step
// that loads the output register, after which the block returns to idle with s_axis_tready
// high. s_axis_tready is low while an item is in progress; a finished result waits in the
// output register while the next item is accepted, and the next result holds in the last
// step until the one before it is taken. gait_period values of 0 and 1 act as 2.
// Configuration registers sit at byte addresses 0x0 gait_period, 0x4 step_len, 0x8
// lift_height and 0xc ground_level, and should be written only while idle.
module trot_foot_trajectory_generator
    import tftg_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // apb configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // [31:0] time_now
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [16:0] front_left_x, [34:17] front_left_z, [51:35] front_right_x,
    // [69:52] front_right_z, [86:70] hind_left_x, [104:87] hind_left_z,
    // [121:105] hind_right_x, [139:122] hind_right_z, [143:140] stance_mask,
    // [159:144] half_phase
    output logic [159:0] m_axis_tdata
);

    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_STEP   = 2'd1;
    localparam logic [1:0] REG_LIFT   = 2'd2;
    localparam logic [1:0] REG_GROUND = 2'd3;

    localparam logic [3:0] MASK_DIAG0 = 4'h9;  // FL and HR in stance
    localparam logic [3:0] MASK_DIAG1 = 4'h6;  // FR and HL in stance

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MSX,
        ST_MWX,
        ST_MZ,
        ST_FIN
    } t_state;

    // configuration registers
    logic [PERIOD_W-1:0] r_period;
    logic [LEN_W-1:0]    r_step;
    logic [LEN_W-1:0]    r_lift;
    logic [GROUND_W-1:0] r_ground;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_step   <= STEP_RST;
            r_lift   <= LIFT_RST;
            r_ground <= GROUND_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_PERIOD: r_period <= pwdata[PERIOD_W-1:0];
                REG_STEP:   r_step   <= pwdata[LEN_W-1:0];
                REG_LIFT:   r_lift   <= pwdata[LEN_W-1:0];
                REG_GROUND: r_ground <= pwdata[GROUND_W-1:0];
                default:    r_period <= r_period;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PERIOD: prdata = {{(32-PERIOD_W){1'b0}}, r_period};
            REG_STEP:   prdata = {{(32-LEN_W){1'b0}}, r_step};
            REG_LIFT:   prdata = {{(32-LEN_W){1'b0}}, r_lift};
            REG_GROUND: prdata = {{(32-GROUND_W){r_ground[GROUND_W-1]}}, r_ground};
            default:    prdata = '0;
        endcase
    end

    // sequencer state and datapath registers
    t_state              r_state,   n_state;
    logic                r_started, n_started;
    logic [TIME_W-1:0]   r_start,   n_start;
    logic                r_diag,    n_diag;
    logic                r_last,    n_last;
    logic [STEP_W-1:0]   r_step_cnt, n_step_cnt;
    logic [TIME_W-1:0]   r_num,     n_num;
    logic [PERIOD_W-1:0] r_div,     n_div;
    logic [PERIOD_W-1:0] r_rem,     n_rem;
    logic [PHASE_W:0]    r_quo,     n_quo;
    logic [SINE_W-1:0]   r_sine,    n_sine;
    logic signed [34:0]  r_prod,    n_prod;
    logic [X_W-1:0]      r_sx,      n_sx;
    logic [X_W-1:0]      r_wx,      n_wx;
    logic                r_mvalid,  n_mvalid;
    logic [159:0]        r_mdata,   n_mdata;

    logic                in_xfer;
    logic [TIME_W-1:0]   base;
    logic [PERIOD_W-1:0] eff_period;
    logic [PERIOD_W:0]   cand;
    logic [PERIOD_W+1:0] diff;
    logic                ge;
    logic [PHASE_W-1:0]  phase;
    logic [PHASE_W-1:0]  u;
    logic [15+SINE_LOG2:0] scaled;
    logic [IDX_W-1:0]    idx;
    logic signed [16:0]  mul_a;
    logic signed [17:0]  mul_b;
    logic signed [34:0]  rnd_x;
    logic [34:0]         rnd_z;
    logic [Z_W-1:0]      sz;
    logic [Z_W-1:0]      wz;
    logic [3:0]          mask;
    logic [X_W-1:0]      x_fl, x_fr, x_hl, x_hr;
    logic [Z_W-1:0]      z_fl, z_fr, z_hl, z_hr;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    assign base       = r_started ? r_start : s_axis_tdata[TIME_W-1:0];
    assign eff_period = (r_period < PERIOD_W'(2)) ? PERIOD_W'(2) : r_period;

    // shared restoring divide step
    assign cand = {r_rem, r_num[TIME_W-1]};
    assign diff = {1'b0, cand} - {2'b00, r_div};
    assign ge   = !diff[PERIOD_W+1];

    // sine lookup from the phase, mirrored about the quarter point
    assign phase  = r_quo[PHASE_W-1:0];
    assign u      = phase[PHASE_W-1] ? PHASE_W'(17'h10000 - {1'b0, phase}) : phase;
    assign scaled = {u, {SINE_LOG2{1'b0}}} + (16+SINE_LOG2)'(16384);
    assign idx    = scaled[15+SINE_LOG2:15];

    // shared multiplier operands
    always_comb begin
        case (r_state)
            ST_MSX: begin
                mul_a = $signed({1'b0, r_step});
                mul_b = $signed(18'sd32768 - $signed({2'b00, phase}));
            end
            ST_MWX: begin
                mul_a = $signed({1'b0, r_step});
                mul_b = $signed({1'b0, phase, 1'b0}) - 18'sd65536;
            end
            ST_MZ: begin
                mul_a = $signed({1'b0, r_lift});
                mul_b = $signed({1'b0, r_sine});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // round half up, then scale by 2^-17 (x) or 2^-16 (z)
    assign rnd_x = r_prod + 35'sd65536;
    assign rnd_z = 35'(r_prod) + 35'd32768;
    assign sz    = {r_ground[GROUND_W-1], r_ground};
    assign wz    = sz + {1'b0, rnd_z[32:16]};
    assign mask  = r_diag ? MASK_DIAG1 : MASK_DIAG0;
    assign x_fl  = mask[0] ? r_sx : r_wx;
    assign x_fr  = mask[1] ? r_sx : r_wx;
    assign x_hl  = mask[2] ? r_sx : r_wx;
    assign x_hr  = mask[3] ? r_sx : r_wx;
    assign z_fl  = mask[0] ? sz : wz;
    assign z_fr  = mask[1] ? sz : wz;
    assign z_hl  = mask[2] ? sz : wz;
    assign z_hr  = mask[3] ? sz : wz;

    always_comb begin
        n_state    = r_state;
        n_started  = r_started;
        n_start    = r_start;
        n_diag     = r_diag;
        n_last     = r_last;
        n_step_cnt = r_step_cnt;
        n_num      = r_num;
        n_div      = r_div;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_sine     = r_sine;
        n_prod     = mul_a * mul_b;
        n_sx       = r_sx;
        n_wx       = r_wx;
        n_mvalid   = r_mvalid && !m_axis_tready;
        n_mdata    = r_mdata;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (!r_started) begin
                        n_started = 1'b1;
                        n_start   = s_axis_tdata[TIME_W-1:0];
                    end
                    n_num      = s_axis_tdata[TIME_W-1:0] - base;
                    n_div      = eff_period;
                    n_rem      = '0;
                    n_step_cnt = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem      = ge ? diff[PERIOD_W-1:0] : cand[PERIOD_W-1:0];
                n_num      = {r_num[TIME_W-2:0], 1'b0};
                n_quo      = {r_quo[PHASE_W-1:0], ge};
                n_step_cnt = r_step_cnt + STEP_W'(1);
                if (r_step_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_MSX;
                end
            end
            ST_MSX: begin
                n_sine = SINE_TAB[idx];
                if (r_quo[PHASE_W] != r_last) begin
                    n_diag = !r_diag;
                    n_last = r_quo[PHASE_W];
                end
                n_state = ST_MWX;
            end
            ST_MWX: begin
                n_sx    = rnd_x[33:17];
                n_state = ST_MZ;
            end
            ST_MZ: begin
                n_wx    = rnd_x[33:17];
                n_state = ST_FIN;
            end
            ST_FIN: begin
                n_prod = r_prod;
                if (!r_mvalid || m_axis_tready) begin
                    n_mvalid = 1'b1;
                    n_mdata  = {phase, mask, z_hr, x_hr, z_hl, x_hl,
                                z_fr, x_fr, z_fl, x_fl};
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_started <= 1'b0;
            r_start   <= '0;
            r_diag    <= 1'b0;
            r_last    <= 1'b0;
            r_mvalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_start   <= n_start;
            r_diag    <= n_diag;
            r_last    <= n_last;
            r_mvalid  <= n_mvalid;
        end
        r_step_cnt <= n_step_cnt;
        r_num      <= n_num;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_sine     <= n_sine;
        r_prod     <= n_prod;
        r_sx       <= n_sx;
        r_wx       <= n_wx;
        r_mdata    <= n_mdata;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_mask_diagonal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[143:140] == MASK_DIAG0 ||
                           m_axis_tdata[143:140] == MASK_DIAG1))
        else $error("stance mask is not a diagonal pair");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_FIN))
        else $error("result shown outside the final step");

    a_started_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_started)
        else $error("start time not latched");
`endif

endmodule

FILE: bench/tb_top.sv
module tb_top;
    import tftg_pkg::*;

    localparam int REG_GAIT_PERIOD  = 0;
    localparam int REG_STEP_LEN     = 1;
    localparam int REG_LIFT_HEIGHT  = 2;
    localparam int REG_GROUND_LEVEL = 3;

    localparam logic [3:0]  STANCE_FL_HR = 4'b1001;
    localparam logic [3:0]  STANCE_FR_HL = 4'b0110;
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;

    localparam int PIPE_CYCLES = 54;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 140;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 700;

    typedef struct packed {
        logic [PHASE_W-1:0] half_phase;
        logic [3:0]         stance_mask;
        logic [Z_W-1:0]     hr_z;
        logic [X_W-1:0]     hr_x;
        logic [Z_W-1:0]     hl_z;
        logic [X_W-1:0]     hl_x;
        logic [Z_W-1:0]     fr_z;
        logic [X_W-1:0]     fr_x;
        logic [Z_W-1:0]     fl_z;
        logic [X_W-1:0]     fl_x;
    } t_pose;

    logic         i_clk;
    logic         i_rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // [31:0] time_now
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [16:0] front_left_x, [34:17] front_left_z, [51:35] front_right_x,
    // [69:52] front_right_z, [86:70] hind_left_x, [104:87] hind_left_z,
    // [121:105] hind_right_x, [139:122] hind_right_z, [143:140] stance_mask,
    // [159:144] half_phase
    logic [159:0] m_axis_tdata;

    trot_foot_trajectory_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow of the block state and registers
    logic        started_q;
    logic [31:0] start_stamp_q;
    logic        diag_sel;
    logic        last_half_q;
    logic [23:0] period_reg;
    logic [15:0] step_reg;
    logic [15:0] lift_reg;
    logic [16:0] ground_reg;
    longint      sine_lut [0:SINE_DEPTH];

    logic [31:0] stamp_q [$];
    t_pose       pose_q [$];

    bit in_fire = 1'b0;
    int cycles = 0;
    int items_in = 0;
    int results_seen = 0;
    int mismatches = 0;
    int settings = 1;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_mode = 0;

    function automatic longint quarter_sine(int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      s;
        x    = (HALF_PI_Q30 * 64'(k) + 64'(SINE_DEPTH / 2)) / 64'(SINE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        s    = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                s = s - longint'(term);
            end else begin
                s = s + longint'(term);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        s = (s + 8192) >>> 14;
        if (s > 65536) begin
            s = 65536;
        end
        return s;
    endfunction

    // floor((num + 2^16) / 2^17), i.e. divide by 2^17 rounding half up
    function automatic longint round_q17(longint num);
        return (num + 65536) >>> 17;
    endfunction

    function automatic t_pose next_pose(logic [31:0] now);
        logic [31:0]     since_start;
        longint unsigned period;
        longint unsigned t;
        longint unsigned half;
        longint unsigned phase;
        longint unsigned u;
        longint unsigned idx;
        longint          g;
        longint          sx;
        longint          wx;
        longint          wz;
        logic [3:0]      mask;
        t_pose           r;
        period = (period_reg < 2) ? 64'd2 : 64'(period_reg);
        if (!started_q) begin
            started_q     = 1'b1;
            start_stamp_q = now;
        end
        since_start = now - start_stamp_q;
        t     = 64'(since_start) % period;
        half  = (2 * t) / period;
        if (half > 1) begin
            half = 1;
        end
        phase = ((2 * t - half * period) << 16) / period;
        if (phase > 65535) begin
            phase = 65535;
        end
        if (half[0] != last_half_q) begin
            diag_sel    = !diag_sel;
            last_half_q = half[0];
        end
        g  = longint'($signed(ground_reg));
        sx = round_q17(longint'(step_reg) * (32768 - longint'(phase)));
        wx = round_q17(longint'(step_reg) * (2 * longint'(phase) - 65536));
        u  = (phase < 32768) ? phase : 65536 - phase;
        idx = (u * SINE_DEPTH + 16384) / 32768;
        if (idx > SINE_DEPTH) begin
            idx = SINE_DEPTH;
        end
        wz = g + ((longint'(lift_reg) * sine_lut[idx] + 32768) >>> 16);
        mask = diag_sel ? STANCE_FR_HL : STANCE_FL_HR;
        r.fl_x = mask[0] ? sx[X_W-1:0] : wx[X_W-1:0];
        r.fl_z = mask[0] ? g[Z_W-1:0]  : wz[Z_W-1:0];
        r.fr_x = mask[1] ? sx[X_W-1:0] : wx[X_W-1:0];
        r.fr_z = mask[1] ? g[Z_W-1:0]  : wz[Z_W-1:0];
        r.hl_x = mask[2] ? sx[X_W-1:0] : wx[X_W-1:0];
        r.hl_z = mask[2] ? g[Z_W-1:0]  : wz[Z_W-1:0];
        r.hr_x = mask[3] ? sx[X_W-1:0] : wx[X_W-1:0];
        r.hr_z = mask[3] ? g[Z_W-1:0]  : wz[Z_W-1:0];
        r.stance_mask = mask;
        r.half_phase  = phase[PHASE_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
        $display("mismatch at result %0d, %s: got %h expected %h",
                 results_seen, what, got_v, want_v);
        mismatches++;
    endtask

    task automatic compare_field(string what, logic [31:0] got_v, logic [31:0] want_v);
        if (got_v !== want_v) begin
            report_mismatch(what, got_v, want_v);
        end
    endtask

    task automatic write_reg(int idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx * 4);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAIT_PERIOD:  period_reg = val[23:0];
            REG_STEP_LEN:     step_reg   = val[15:0];
            REG_LIFT_HEIGHT:  lift_reg   = val[15:0];
            REG_GROUND_LEVEL: ground_reg = val[16:0];
            default: ;
        endcase
    endtask

    // nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
            #1;
        end while (stamp_q.size() != 0 || s_axis_tvalid || pose_q.size() != 0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, pose_q.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // result check first, so a result can never match the item accepted at the same edge
    always @(posedge i_clk) begin : monitor
        t_pose got;
        t_pose want;
        if (!i_rst_n) begin
            in_fire = 1'b0;
        end else begin
            in_fire = s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pose_q.size() == 0) begin
                    report_mismatch("result with none expected", got.half_phase, '0);
                end else begin
                    want = pose_q.pop_front();
                    compare_field("front_left_x",  got.fl_x, want.fl_x);
                    compare_field("front_left_z",  got.fl_z, want.fl_z);
                    compare_field("front_right_x", got.fr_x, want.fr_x);
                    compare_field("front_right_z", got.fr_z, want.fr_z);
                    compare_field("hind_left_x",   got.hl_x, want.hl_x);
                    compare_field("hind_left_z",   got.hl_z, want.hl_z);
                    compare_field("hind_right_x",  got.hr_x, want.hr_x);
                    compare_field("hind_right_z",  got.hr_z, want.hr_z);
                    compare_field("stance_mask",   got.stance_mask, want.stance_mask);
                    compare_field("half_phase",    got.half_phase, want.half_phase);
                end
                results_seen++;
            end
            if (in_fire) begin
                pose_q.push_back(next_pose(s_axis_tdata));
                items_in++;
            end
        end
    end

    // sender: bursts of transfers separated by random gaps
    always @(negedge i_clk) begin : sender
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (stamp_q.size() > 0) begin
                s_axis_tdata  <= stamp_q.pop_front();
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    case ($urandom_range(0, 2))
                        0:       gap_left = 0;
                        1:       gap_left = $urandom_range(1, 60);
                        default: gap_left = $urandom_range(1, 200);
                    endcase
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern drawn at random from four modes, plus one long hold-off
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (!hold_done && items_in >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (cycles % 256 == 0) begin
                stall_mode = $urandom_range(0, 3);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ((cycles % 16) < 5);
                endcase
            end
        end
    end

    initial begin : main
        logic [31:0] base;
        logic [31:0] stamp;
        logic [23:0] per;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            sine_lut[k] = quarter_sine(k);
        end
        started_q     = 1'b0;
        start_stamp_q = '0;
        diag_sel      = 1'b0;
        last_half_q   = 1'b0;
        period_reg    = 24'd2000000;
        step_reg      = 16'd6554;
        lift_reg      = 16'd4588;
        ground_reg    = 17'h1B852;   // -18350
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: first transfer latches a start near the top of the time range,
        // then half-cycle edges and a wrap of the timestamp
        base = 32'hFFFF_FF00;
        stamp_q.push_back(base);
        stamp_q.push_back(base);
        stamp_q.push_back(base + 999999);
        stamp_q.push_back(base + 1000000);
        stamp_q.push_back(base + 1999999);
        stamp_q.push_back(base + 2000000);
        stamp_q.push_back(32'hFFFF_FFFF);
        stamp_q.push_back(32'h0000_0000);
        wait_idle();

        // periods of one and zero behave as two
        write_reg(REG_GAIT_PERIOD, 32'd1);
        settings++;
        for (int i = 0; i < 4; i++) begin
            stamp_q.push_back(base + i);
        end
        wait_idle();
        write_reg(REG_GAIT_PERIOD, 32'd0);
        settings++;
        stamp_q.push_back(base + 5);
        stamp_q.push_back(base + 7);
        stamp_q.push_back(base + 8);
        wait_idle();

        // every register at its top value, phase driven to both ends
        write_reg(REG_GAIT_PERIOD, 32'hFF_FFFF);
        write_reg(REG_STEP_LEN, 32'hFFFF);
        write_reg(REG_LIFT_HEIGHT, 32'hFFFF);
        write_reg(REG_GROUND_LEVEL, 32'h0_FFFF);
        settings++;
        stamp_q.push_back(base + 32'h3F_FFFF);
        stamp_q.push_back(base + 32'h7F_FFFF);
        stamp_q.push_back(base + 32'h80_0000);
        stamp_q.push_back(base + 32'hBF_FFFF);
        stamp_q.push_back(base + 32'hFF_FFFE);
        wait_idle();

        // lowest ground, no step and no lift
        write_reg(REG_GROUND_LEVEL, 32'h1_0000);
        write_reg(REG_STEP_LEN, 32'h0);
        write_reg(REG_LIFT_HEIGHT, 32'h0);
        settings++;
        stamp_q.push_back(base + 32'h3F_FFFF);
        stamp_q.push_back(base + 32'h40_0000);
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0:       per = $urandom_range(2, 40);
                1:       per = $urandom_range(2, 5000);
                2:       per = $urandom_range(2, 24'hFF_FFFF);
                3:       per = $urandom_range(0, 1);
                default: per = 24'hFF_FFFF;
            endcase
            write_reg(REG_GAIT_PERIOD, 32'(per));
            case ($urandom_range(0, 3))
                0:       write_reg(REG_STEP_LEN, 32'hFFFF);
                1:       write_reg(REG_STEP_LEN, 32'h0);
                default: write_reg(REG_STEP_LEN, $urandom_range(0, 16'hFFFF));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(REG_LIFT_HEIGHT, 32'hFFFF);
                1:       write_reg(REG_LIFT_HEIGHT, 32'h0);
                default: write_reg(REG_LIFT_HEIGHT, $urandom_range(0, 16'hFFFF));
            endcase
            write_reg(REG_GROUND_LEVEL, $urandom_range(0, 17'h1_FFFF));
            settings++;
            stamp = $urandom;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // mostly forward steps within a fraction of the period, with some noise
                case ($urandom_range(0, 9))
                    0:       stamp = $urandom;
                    1:       stamp = stamp;
                    2:       stamp = stamp - $urandom_range(1, per + 1);
                    default: stamp = stamp + $urandom_range(0, per / 3 + 1);
                endcase
                stamp_q.push_back(stamp);
            end
            wait_idle();
        end

        repeat (PIPE_CYCLES + 10) @(posedge i_clk);
        $display("%0d timestamps driven, %0d foot poses checked over %0d register settings",
                 items_in, results_seen, settings);
        $display("receiver hold-off %s, %0d mismatches", hold_done ? "done" : "not reached",
                 mismatches);
        if (mismatches == 0 && pose_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/tftg_pkg.sv
design/trot_foot_trajectory_generator.sv
bench/tb_top.sv
